// File: hdl/m2s_fir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package m2s_fir_pkg;

    // Default configuration of the filter core.
    localparam int MAX_TAPS_DEF    = 512;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed arithmetic widths: 40-bit accumulator, Q1.23 results.
    localparam int ACC_BITS = 40;
    localparam int OUT_BITS = 24;
    localparam int OUT_FRAC = 23;

    // Request kinds carried on the input tuser.
    localparam int FUNC_BITS = 2;
    localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD_TAPS = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR     = 2'd2;

endpackage

`default_nettype wire

// File: hdl/mono_to_stereo_dual_fir_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Mono-in, stereo-out dual FIR. Each sample request writes its Q1.15 sample
// into a circular history of ir_length entries and convolves the history,
// newest first, with a left and a right impulse response; each Q2.30 sum is
// kept in a 40-bit wrapping accumulator, rounded half up to Q1.23, added to
// the incoming left or right value, and saturated to 24 bits with a flag on
// clipping. After a sample request the next request is taken only once its
// result is valid, provided the output register is free: the sequencer
// issues one tap pair per cycle through the single read port of the history
// memory and of the tap memory, followed by a two-stage read/multiply
// pipeline and the round and saturate stages. With ir_length 0 the result
// (the unchanged accumulator inputs) goes through the hold state into the
// output register, and the next request can be taken once it is valid. While
// an earlier result still waits in the output register, the new result is
// held back until that one is taken. Tap loads and history clears are done
// at acceptance and give no result. The finished result sits in an output
// register, so a new request is accepted while it waits to be taken. Writing
// ir_length clears the history and the write position; a fill count stands in
// for clearing the history memory, so there is no clearing pass after reset.
module mono_to_stereo_dual_fir_core #(
    parameter int MAX_TAPS    = m2s_fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = m2s_fir_pkg::SAMPLE_BITS_DEF,
    localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int LEN_W  = $clog2(MAX_TAPS + 1),
    localparam int IN_BITS = 3 * SAMPLE_BITS + 2 * m2s_fir_pkg::OUT_BITS + IDX_W,
    localparam int IN_W   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W  = 2 * m2s_fir_pkg::OUT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Configuration: ir_length.
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]                    i_cfg_wr_data,

    // Request stream.
    input  wire logic                                i_s_axis_tvalid,
    output      logic                                o_s_axis_tready,
    // From bit 0: sample, acc_in_left, acc_in_right, tap_index, coef_left,
    // coef_right, zero padding.
    input  wire logic [IN_W-1:0]                     i_s_axis_tdata,
    // func.
    input  wire logic [m2s_fir_pkg::FUNC_BITS-1:0]   i_s_axis_tuser,

    // Result stream.
    output      logic                                o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // From bit 0: out_left, out_right.
    output      logic [OUT_W-1:0]                    o_m_axis_tdata,
    // saturated.
    output      logic                                o_m_axis_tuser
);

    localparam int SB      = SAMPLE_BITS;
    localparam int OB      = m2s_fir_pkg::OUT_BITS;
    localparam int ACC_W   = m2s_fir_pkg::ACC_BITS;
    localparam int PROD_W  = 2 * SB;
    localparam int SUM_W   = ACC_W + 12;
    localparam int SH      = 2 * (SB - 1) - m2s_fir_pkg::OUT_FRAC;
    localparam int RSH     = (SH > 0) ? SH : 0;
    localparam int LSH     = (SH < 0) ? -SH : 0;
    localparam logic signed [SUM_W-1:0] HALF   = SUM_W'((2 ** RSH) / 2);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (OB - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (OB - 1)));

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RUN   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_HOLD  = 6'b100000
    } t_state;

    // Request fields.
    logic signed [SB-1:0]  s_sample;
    logic signed [OB-1:0]  s_acc_l;
    logic signed [OB-1:0]  s_acc_r;
    logic [IDX_W-1:0]      s_tap;
    logic [SB-1:0]         s_coef_l;
    logic [SB-1:0]         s_coef_r;
    logic [m2s_fir_pkg::FUNC_BITS-1:0] s_func;

    assign s_sample = i_s_axis_tdata[SB-1:0];
    assign s_acc_l  = i_s_axis_tdata[SB +: OB];
    assign s_acc_r  = i_s_axis_tdata[SB + OB +: OB];
    assign s_tap    = i_s_axis_tdata[SB + 2 * OB +: IDX_W];
    assign s_coef_l = i_s_axis_tdata[SB + 2 * OB + IDX_W +: SB];
    assign s_coef_r = i_s_axis_tdata[2 * SB + 2 * OB + IDX_W +: SB];
    assign s_func   = i_s_axis_tuser;

    t_state                r_state;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_fill;
    logic [IDX_W-1:0]      r_wpos;
    logic [IDX_W-1:0]      r_k;
    logic [IDX_W-1:0]      r_hidx;
    logic signed [OB-1:0]  r_accin_l;
    logic signed [OB-1:0]  r_accin_r;

    // Memories and their registered read data.
    logic signed [SB-1:0]  r_hist_mem [MAX_TAPS];
    logic [2*SB-1:0]       r_tap_mem [MAX_TAPS];
    logic signed [SB-1:0]  r_hist_rd;
    logic [2*SB-1:0]       r_tap_rd;

    // Read and product pipeline.
    logic                  r_rd_v;
    logic                  r_rd_hv;
    logic                  r_rd_last;
    logic                  r_prod_v;
    logic                  r_prod_last;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    logic signed [ACC_W-1:0]  r_acc_l;
    logic signed [ACC_W-1:0]  r_acc_r;
    logic signed [SUM_W-1:0]  r_rnd_l;
    logic signed [SUM_W-1:0]  r_rnd_r;

    // Finished result and output register.
    logic signed [OB-1:0]  r_res_l;
    logic signed [OB-1:0]  r_res_r;
    logic                  r_res_sat;
    logic                  r_out_v;
    logic signed [OB-1:0]  r_out_l;
    logic signed [OB-1:0]  r_out_r;
    logic                  r_out_sat;

    logic                  in_acc;
    logic                  is_sample;
    logic                  is_load;
    logic [IDX_W-1:0]      len_m1;
    logic [LEN_W-1:0]      n_len;
    logic                  out_free;
    logic signed [SB-1:0]  hist_op;
    logic signed [SB-1:0]  tap_l;
    logic signed [SB-1:0]  tap_r;
    logic signed [SUM_W-1:0] tot_l;
    logic signed [SUM_W-1:0] tot_r;
    logic                  clip_l;
    logic                  clip_r;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign is_sample = in_acc && (s_func == m2s_fir_pkg::FUNC_SAMPLE);
    assign is_load   = in_acc && (s_func == m2s_fir_pkg::FUNC_LOAD_TAPS)
                       && (LEN_W'(s_tap) < LEN_W'(MAX_TAPS));
    assign len_m1    = IDX_W'(r_len - LEN_W'(1));
    assign out_free  = !r_out_v || i_m_axis_tready;

    // A written length above the tap count is clipped to it.
    assign n_len = (i_cfg_wr_data > LEN_W'(MAX_TAPS)) ? LEN_W'(MAX_TAPS) : i_cfg_wr_data;

    // History entries not written since the last clear read as zero.
    assign hist_op = r_rd_hv ? r_hist_rd : '0;
    assign tap_l   = r_tap_rd[SB-1:0];
    assign tap_r   = r_tap_rd[2*SB-1:SB];

    // Add the rounded sums to the incoming values and saturate.
    always_comb begin
        tot_l  = r_rnd_l + SUM_W'(r_accin_l);
        tot_r  = r_rnd_r + SUM_W'(r_accin_r);
        clip_l = (tot_l > SAT_HI) || (tot_l < SAT_LO);
        clip_r = (tot_r > SAT_HI) || (tot_r < SAT_LO);
    end

    // History memory: the new sample is written at acceptance, reads follow.
    always_ff @(posedge i_clk) begin
        if (is_sample && (r_len != '0)) begin
            r_hist_mem[r_wpos] <= s_sample;
        end
        r_hist_rd <= r_hist_mem[r_hidx];
    end

    // Tap memory: right coefficient in the upper half of each word.
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_tap_mem[s_tap] <= {s_coef_r, s_coef_l};
        end
        r_tap_rd <= r_tap_mem[r_k];
    end

    // Sequencer, write position and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_fill  <= '0;
            r_wpos  <= '0;
            r_k     <= '0;
            r_hidx  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len  <= n_len;
                r_fill <= '0;
                r_wpos <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (s_func == m2s_fir_pkg::FUNC_CLEAR)) begin
                        r_fill <= '0;
                        r_wpos <= '0;
                    end
                    if (is_sample) begin
                        if (r_len == '0) begin
                            r_state <= ST_HOLD;
                        end else begin
                            r_state <= ST_RUN;
                            r_k     <= '0;
                            r_hidx  <= r_wpos;
                            r_wpos  <= (r_wpos == len_m1) ? '0 : r_wpos + IDX_W'(1);
                            if (r_fill != r_len) begin
                                r_fill <= r_fill + LEN_W'(1);
                            end
                        end
                    end
                end
                ST_RUN: begin
                    r_k    <= r_k + IDX_W'(1);
                    r_hidx <= (r_hidx == '0) ? len_m1 : r_hidx - IDX_W'(1);
                    if (r_k == len_m1) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_prod_v && r_prod_last) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Pipeline control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v      <= 1'b0;
            r_rd_hv     <= 1'b0;
            r_rd_last   <= 1'b0;
            r_prod_v    <= 1'b0;
            r_prod_last <= 1'b0;
        end else begin
            r_rd_v      <= (r_state == ST_RUN);
            r_rd_hv     <= (LEN_W'(r_hidx) < r_fill);
            r_rd_last   <= (r_k == len_m1);
            r_prod_v    <= r_rd_v;
            r_prod_last <= r_rd_last;
        end
    end

    // Multiply, accumulate, round and saturate.
    always_ff @(posedge i_clk) begin
        r_prod_l <= hist_op * tap_l;
        r_prod_r <= hist_op * tap_r;
        if (is_sample) begin
            r_acc_l   <= '0;
            r_acc_r   <= '0;
            r_accin_l <= s_acc_l;
            r_accin_r <= s_acc_r;
        end else if (r_prod_v) begin
            r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
            r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
        end
        r_rnd_l <= ((SUM_W'(r_acc_l) <<< LSH) + HALF) >>> RSH;
        r_rnd_r <= ((SUM_W'(r_acc_r) <<< LSH) + HALF) >>> RSH;
        if (is_sample && (r_len == '0)) begin
            r_res_l   <= s_acc_l;
            r_res_r   <= s_acc_r;
            r_res_sat <= 1'b0;
        end else if (r_state == ST_ADD) begin
            r_res_l   <= clip_l ? ((tot_l > SAT_HI) ? OB'(SAT_HI) : OB'(SAT_LO)) : OB'(tot_l);
            r_res_r   <= clip_r ? ((tot_r > SAT_HI) ? OB'(SAT_HI) : OB'(SAT_LO)) : OB'(tot_r);
            r_res_sat <= clip_l || clip_r;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((r_state == ST_HOLD) && out_free) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_HOLD) && out_free) begin
            r_out_l   <= r_res_l;
            r_out_r   <= r_res_r;
            r_out_sat <= r_res_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_r, r_out_l};
    assign o_m_axis_tuser  = r_out_sat;

endmodule

`default_nettype wire
